### design/rmj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared types and constants of the radar measurement Jacobian block.
// ----------------------------------------------------------------------------
package rmj_pkg;

    // Default number of fraction bits of the fixed-point fields
    localparam int FRAC_BITS_DEF = 16;

    // Width of one fixed-point field and of a divider quotient
    localparam int DATA_W = 32;
    localparam int QUO_W  = 32;

    // Width of the squared-range threshold register and its reset value
    localparam int                MIN_W         = 31;
    localparam logic [MIN_W-1:0]  MIN_RANGE_RST = 31'd66;

    // One state word
    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } t_in;

    // One Jacobian word: the six distinct nonzero entries and the flag
    typedef struct packed {
        logic signed [DATA_W-1:0] range_dpx;
        logic signed [DATA_W-1:0] range_dpy;
        logic signed [DATA_W-1:0] bearing_dpx;
        logic signed [DATA_W-1:0] bearing_dpy;
        logic signed [DATA_W-1:0] rate_dpx;
        logic signed [DATA_W-1:0] rate_dpy;
        logic                     degenerate;
    } t_out;

endpackage
`default_nettype wire

### design/radar_measurement_jacobian.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Radar measurement Jacobian of an extended Kalman filter, fixed point.
// ----------------------------------------------------------------------------
// The block takes one state word (px, py, vx, vy) per cycle while not held
// and returns the six distinct nonzero Jacobian entries and a degenerate
// flag. The pipeline is the chain of the product stage, the squared-range
// sum, a 33-stage square root, a 34-stage divider for range, two stages
// for the rate products and a 34-stage divider for range rate; the bearing
// dividers run alongside the square root. Every stage takes a new word each
// cycle while the pipeline is not held, so sustained rate is one word per
// cycle. An output register and a skid register sit behind the pipeline:
// while a result waits, one more word is still taken, and the pipeline
// holds only when both are full. The threshold register is written through
// the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian #(
    parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire rmj_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output rmj_pkg::t_out                  o_out_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [rmj_pkg::MIN_W-1:0] i_cfg_data
);

    import rmj_pkg::*;

    localparam int SQ_LAT  = 33;
    localparam int DIV_LAT = QUO_W + 2;
    localparam int T_C1    = 2;
    localparam int T_SQ    = T_C1 + SQ_LAT;
    localparam int T_RX    = T_SQ + DIV_LAT;
    localparam int T_MUL   = T_RX + 2;
    localparam int T_END   = T_MUL + DIV_LAT;
    localparam int T_BR    = T_C1 + DIV_LAT;
    localparam int RW      = QUO_W + 2;
    localparam logic [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

    // Saturate a quotient magnitude to a signed word
    function automatic logic [DATA_W-1:0] f_sat(input logic neg, input logic [QUO_W:0] q,
                                                 input logic ovf);
        logic big;
        big = ovf | q[QUO_W] | q[DATA_W-1];
        if (big) begin
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return neg ? (32'd0 - q[DATA_W-1:0]) : q[DATA_W-1:0];
    endfunction

    logic             w_en;
    logic [MIN_W-1:0] r_min_range_sq;

    // Stage 1: products
    logic               r1_v;
    logic signed [63:0] r1_pxx, r1_pyy, r1_a, r1_b;
    logic        [31:0] r1_mag_px, r1_mag_py;
    logic               r1_px_neg, r1_py_neg;
    logic        [31:0] w_px_u, w_py_u;

    // Stage 2: squared range and cross term
    logic               r2_v;
    logic        [63:0] r2_c1, r2_xmag;
    logic               r2_xneg;
    logic        [31:0] r2_mag_px, r2_mag_py;
    logic               r2_px_neg, r2_py_neg;
    logic        [64:0] w_x;

    // Stage 3: degenerate test
    logic               r3_degen;
    logic        [63:0] w_c1r, w_c1q;

    // Square root and range dividers
    logic               sq_v;
    logic        [31:0] sq_root;
    logic        [63:0] d_mag;
    logic               rx_v;
    logic   [QUO_W:0]   rx_q, ry_q;
    logic               rx_ovf, ry_ovf;

    // Bearing dividers
    logic   [QUO_W:0]   bx_q, by_q;
    logic               bx_ovf, by_ovf;

    // Rate products
    logic        [63:0] d_xmag, d_c1;
    logic               r70_v, r71_v;
    logic        [63:0] r70_pl_x, r70_ph_x, r70_pl_y, r70_ph_y;
    logic        [95:0] r71_num_x, r71_num_y;

    // Rate dividers and aligned side data
    logic               p_v;
    logic   [QUO_W:0]   tx_q, ty_q;
    logic               tx_ovf, ty_ovf;
    logic [2*RW-1:0]    d_br, d_rr;
    logic        [2:0]  d_sign;
    logic               d_degen;
    t_out               w_res;

    // Output register and skid
    logic               r_out_v, r_skid_v;
    t_out               r_out, r_skid;
    logic               w_take;

    assign w_en        = !r_skid_v;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range_sq <= MIN_RANGE_RST;
        end else if (i_cfg_valid) begin
            r_min_range_sq <= i_cfg_data;
        end
    end

    // Stage 1: square the position, form both cross products
    assign w_px_u = i_in_data.pos_x;
    assign w_py_u = i_in_data.pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
        end
        if (w_en) begin
            r1_pxx    <= i_in_data.pos_x * i_in_data.pos_x;
            r1_pyy    <= i_in_data.pos_y * i_in_data.pos_y;
            r1_a      <= i_in_data.vel_x * i_in_data.pos_y;
            r1_b      <= i_in_data.vel_y * i_in_data.pos_x;
            r1_mag_px <= w_px_u[31] ? (32'd0 - w_px_u) : w_px_u;
            r1_mag_py <= w_py_u[31] ? (32'd0 - w_py_u) : w_py_u;
            r1_px_neg <= w_px_u[31];
            r1_py_neg <= w_py_u[31];
        end
    end

    // Stage 2: sum the squares, take sign and magnitude of the cross term
    assign w_x = {r1_a[63], r1_a} - {r1_b[63], r1_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            r2_c1     <= $unsigned(r1_pxx) + $unsigned(r1_pyy);
            r2_xneg   <= w_x[64];
            r2_xmag   <= w_x[64] ? 64'(65'd0 - w_x) : w_x[63:0];
            r2_mag_px <= r1_mag_px;
            r2_mag_py <= r1_mag_py;
            r2_px_neg <= r1_px_neg;
            r2_py_neg <= r1_py_neg;
        end
    end

    // Stage 3: round the squared range and test it against the threshold
    assign w_c1r = r2_c1 + (64'd1 << (FRAC_BITS - 1));
    assign w_c1q = w_c1r >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_degen <= (w_c1q < 64'(r_min_range_sq)) || (w_c1q == 64'd0);
        end
    end

    // Range: square root, then position over range
    rmj_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_n     (r2_c1),
        .o_valid (sq_v),
        .o_root  (sq_root)
    );

    rmj_delay #(.W(64), .DEPTH(SQ_LAT)) u_dly_mag (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r2_mag_px, r2_mag_py}),
        .o_d   (d_mag)
    );

    rmj_div #(.NW(32 + FRAC_BITS), .DW(32), .QW(QUO_W)) u_div_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (sq_v),
        .i_num   ({d_mag[63:32], {FRAC_BITS{1'b0}}}),
        .i_den   (sq_root),
        .o_valid (rx_v),
        .o_quo   (rx_q),
        .o_ovf   (rx_ovf)
    );

    rmj_div #(.NW(32 + FRAC_BITS), .DW(32), .QW(QUO_W)) u_div_ry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (sq_v),
        .i_num   ({d_mag[31:0], {FRAC_BITS{1'b0}}}),
        .i_den   (sq_root),
        .o_valid (),
        .o_quo   (ry_q),
        .o_ovf   (ry_ovf)
    );

    // Bearing: position over squared range
    rmj_div #(.NW(32 + 2 * FRAC_BITS), .DW(64), .QW(QUO_W)) u_div_bx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_num   ({r2_mag_py, {(2 * FRAC_BITS){1'b0}}}),
        .i_den   (r2_c1),
        .o_valid (),
        .o_quo   (bx_q),
        .o_ovf   (bx_ovf)
    );

    rmj_div #(.NW(32 + 2 * FRAC_BITS), .DW(64), .QW(QUO_W)) u_div_by (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_num   ({r2_mag_px, {(2 * FRAC_BITS){1'b0}}}),
        .i_den   (r2_c1),
        .o_valid (),
        .o_quo   (by_q),
        .o_ovf   (by_ovf)
    );

    // Rate: unsaturated range entries times the cross term, in two halves
    rmj_delay #(.W(64), .DEPTH(T_RX - T_C1)) u_dly_xmag (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r2_xmag),
        .o_d   (d_xmag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r70_v <= 1'b0;
            r71_v <= 1'b0;
        end else if (w_en) begin
            r70_v <= rx_v;
            r71_v <= r70_v;
        end
        if (w_en) begin
            r70_pl_x  <= ry_q[31:0] * d_xmag[31:0];
            r70_ph_x  <= ry_q[31:0] * d_xmag[63:32];
            r70_pl_y  <= rx_q[31:0] * d_xmag[31:0];
            r70_ph_y  <= rx_q[31:0] * d_xmag[63:32];
            r71_num_x <= {32'd0, r70_pl_x} + {r70_ph_x, 32'd0};
            r71_num_y <= {32'd0, r70_pl_y} + {r70_ph_y, 32'd0};
        end
    end

    rmj_delay #(.W(64), .DEPTH(T_MUL - T_C1)) u_dly_c1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r2_c1),
        .o_d   (d_c1)
    );

    rmj_div #(.NW(96), .DW(64), .QW(QUO_W)) u_div_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r71_v),
        .i_num   (r71_num_x),
        .i_den   (d_c1),
        .o_valid (p_v),
        .o_quo   (tx_q),
        .o_ovf   (tx_ovf)
    );

    rmj_div #(.NW(96), .DW(64), .QW(QUO_W)) u_div_ty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r71_v),
        .i_num   (r71_num_y),
        .i_den   (d_c1),
        .o_valid (),
        .o_quo   (ty_q),
        .o_ovf   (ty_ovf)
    );

    // Align the earlier results, signs and flag with the rate quotients
    rmj_delay #(.W(2 * RW), .DEPTH(T_END - T_BR)) u_dly_br (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({bx_ovf, bx_q, by_ovf, by_q}),
        .o_d   (d_br)
    );

    rmj_delay #(.W(2 * RW), .DEPTH(T_END - T_RX)) u_dly_rr (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({rx_ovf, rx_q, ry_ovf, ry_q}),
        .o_d   (d_rr)
    );

    rmj_delay #(.W(3), .DEPTH(T_END - T_C1)) u_dly_sign (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r2_px_neg, r2_py_neg, r2_xneg}),
        .o_d   (d_sign)
    );

    rmj_delay #(.W(1), .DEPTH(T_END - T_C1 - 1)) u_dly_degen (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r3_degen),
        .o_d   (d_degen)
    );

    // Saturate each entry, or substitute ones for a degenerate range
    always_comb begin
        if (d_degen) begin
            w_res.range_dpx   = ONE;
            w_res.range_dpy   = ONE;
            w_res.bearing_dpx = ONE;
            w_res.bearing_dpy = ONE;
            w_res.rate_dpx    = ONE;
            w_res.rate_dpy    = ONE;
            w_res.degenerate  = 1'b1;
        end else begin
            w_res.range_dpx   = f_sat(d_sign[2], d_rr[2*RW-2:RW], d_rr[2*RW-1]);
            w_res.range_dpy   = f_sat(d_sign[1], d_rr[RW-2:0], d_rr[RW-1]);
            w_res.bearing_dpx = f_sat(!d_sign[1], d_br[2*RW-2:RW], d_br[2*RW-1]);
            w_res.bearing_dpy = f_sat(d_sign[2], d_br[RW-2:0], d_br[RW-1]);
            w_res.rate_dpx    = f_sat(d_sign[1] != d_sign[0], tx_q, tx_ovf);
            w_res.rate_dpy    = f_sat(d_sign[2] == d_sign[0], ty_q, ty_ovf);
            w_res.degenerate  = 1'b0;
        end
    end

    // Output register with skid: hold the pipeline only when both are full
    assign w_take = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (p_v) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (p_v) begin
            if (!r_out_v || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

### design/rmj_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_delay
// Shift line that keeps side data in step with the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rmj_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);

    logic [W-1:0] r_tap [DEPTH];

    // Advance all taps together with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule
`default_nettype wire

### design/rmj_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_isqrt
// Pipelined square root of a 64-bit value, rounded to nearest.
// One result bit per stage, 32 stages plus a rounding stage.
// ----------------------------------------------------------------------------
module rmj_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_n,
    output logic             o_valid,
    output logic      [31:0] o_root
);

    localparam int STEPS = 32;

    logic [63:0] r_n   [STEPS];
    logic [63:0] r_res [STEPS];
    logic        r_v   [STEPS];
    logic        r_vo;
    logic [31:0] r_root;
    logic        w_up;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] s_n;
        logic [63:0] s_res;
        logic        s_v;
        logic [63:0] t_sum;

        if (k == 0) begin : g_first
            assign s_n   = i_n;
            assign s_res = '0;
            assign s_v   = i_valid;
        end else begin : g_next
            assign s_n   = r_n[k-1];
            assign s_res = r_res[k-1];
            assign s_v   = r_v[k-1];
        end

        assign t_sum = s_res + BIT;

        // Try the next root bit, keep the remainder
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
            if (i_en) begin
                if (s_n >= t_sum) begin
                    r_n[k]   <= s_n - t_sum;
                    r_res[k] <= (s_res >> 1) + BIT;
                end else begin
                    r_n[k]   <= s_n;
                    r_res[k] <= s_res >> 1;
                end
            end
        end
    end

    // Round up when the remainder is above the floor root
    assign w_up = r_n[STEPS-1] > r_res[STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[STEPS-1];
        end
        if (i_en) begin
            r_root <= r_res[STEPS-1][31:0] + {31'd0, w_up};
        end
    end

    assign o_valid = r_vo;
    assign o_root  = r_root;

endmodule
`default_nettype wire

### design/rmj_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined unsigned divider, rounded to nearest with ties up.
// A first stage flags quotients of more than QW bits, then one quotient
// bit per stage and a rounding stage.
// ----------------------------------------------------------------------------
module rmj_div #(
    parameter int NW = 64,
    parameter int DW = 64,
    parameter int QW = rmj_pkg::QUO_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_valid,
    output logic    [QW:0]     o_quo,
    output logic               o_ovf
);

    localparam int W0 = NW - QW;
    localparam int CW = (W0 > DW) ? W0 : DW;

    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic          r_ovf [QW+1];
    logic          r_v   [QW+1];
    logic [CW-1:0] w_hi;
    logic [CW-1:0] w_den;
    logic          w_rnd;
    logic [QW:0]   r_quo;
    logic          r_ovf_o;
    logic          r_vo;

    assign w_hi  = CW'(i_num[NW-1:QW]);
    assign w_den = CW'(i_den);

    // Load the upper dividend bits, flag a quotient that would not fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0] <= w_hi[DW-1:0];
            r_low[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= w_hi >= w_den;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] t_try;
        logic [DW:0] t_diff;
        logic        t_ge;

        assign t_try  = {r_rem[k], r_low[k][QW-1]};
        assign t_ge   = t_try >= {1'b0, r_den[k]};
        assign t_diff = t_try - {1'b0, r_den[k]};

        // Shift in one dividend bit, subtract when it fits
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1] <= t_ge ? t_diff[DW-1:0] : t_try[DW-1:0];
                r_low[k+1] <= {r_low[k][QW-2:0], t_ge};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // Round: add one when twice the remainder reaches the divisor
    assign w_rnd = {r_rem[QW], 1'b0} >= {1'b0, r_den[QW]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[QW];
        end
        if (i_en) begin
            r_quo   <= {1'b0, r_low[QW]} + {{QW{1'b0}}, w_rnd};
            r_ovf_o <= r_ovf[QW];
        end
    end

    assign o_valid = r_vo;
    assign o_quo   = r_quo;
    assign o_ovf   = r_ovf_o;

endmodule
`default_nettype wire

### design/rmj_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_check
// Port-level checks of the radar measurement Jacobian, bound to the top.
// ----------------------------------------------------------------------------
module rmj_check #(
    parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_ready,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire rmj_pkg::t_out             o_out_data
);

    import rmj_pkg::*;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // Input side blocks only while a result is waiting
    a_ready_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input blocked with no result waiting");

    // Input ready drops only after a stalled output cycle
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready fell without output stall");

    // Degenerate words carry ones in every entry
    a_degen_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.range_dpx == ONE && o_out_data.range_dpy == ONE &&
            o_out_data.bearing_dpx == ONE && o_out_data.bearing_dpy == ONE &&
            o_out_data.rate_dpx == ONE && o_out_data.rate_dpy == ONE)
        else $error("degenerate word with entries other than one");

endmodule

bind radar_measurement_jacobian rmj_check #(.FRAC_BITS(FRAC_BITS)) u_rmj_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

### sim/radar_measurement_jacobian_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_tb
// Self-checking bench: drives random and corner state words with bursty
// valid and a stalling sink, predicts each Jacobian word, compares in order.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_tb;
    import rmj_pkg::*;

    localparam int FB       = FRAC_BITS_DEF;
    localparam int LATENCY  = 105;
    localparam int WDOG_MAX = 20000;

    // Scoreboard: predicts Jacobian words and checks them in order
    class jacobian_sb;
        t_out        pending[$];
        logic [30:0] thresh;
        int          n_err;

        function new();
            thresh = MIN_RANGE_RST;
            n_err  = 0;
        endfunction

        // round(a*b/d), ties away from zero, all ones on overflow
        function automatic logic [63:0] mdr(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] d);
            logic [127:0] p;
            logic [127:0] q;
            logic [127:0] r;
            p = {64'd0, a} * {64'd0, b};
            q = p / {64'd0, d};
            r = p % {64'd0, d};
            if (r >= {64'd0, d} - r) q = q + 1;
            return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
        endfunction

        function automatic logic [63:0] sqrt_near(logic [63:0] n);
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            logic [127:0] rem;
            lo = 0;
            hi = 64'hFFFF_FFFF;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if ({64'd0, mid} * mid <= {64'd0, n}) lo = mid;
                else hi = mid - 1;
            end
            rem = {64'd0, n} - {64'd0, lo} * lo;
            return (rem > {64'd0, lo}) ? lo + 1 : lo;
        endfunction

        function automatic logic [31:0] clamp(bit neg, logic [63:0] mag);
            if (mag == 0) return 0;
            if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        endfunction

        function automatic logic [63:0] absv(logic signed [63:0] v);
            return v < 0 ? -v : v;
        endfunction

        // Note an accepted state word
        function void note_state(t_in w);
            logic signed [63:0] px, py, vx, vy, sa, sb;
            logic [63:0] c1, c1q, c2, rx, ry, xm;
            bit xn;
            t_out e;
            px = w.pos_x; py = w.pos_y; vx = w.vel_x; vy = w.vel_y;
            c1 = px * px + py * py;
            c1q = (c1 + (64'd1 << (FB - 1))) >> FB;
            if (c1q < {33'd0, thresh} || c1q == 0) begin
                e.range_dpx = 1 << FB; e.range_dpy = 1 << FB;
                e.bearing_dpx = 1 << FB; e.bearing_dpy = 1 << FB;
                e.rate_dpx = 1 << FB; e.rate_dpy = 1 << FB;
                e.degenerate = 1'b1;
            end else begin
                c2 = sqrt_near(c1);
                rx = mdr(absv(px), 64'd1 << FB, c2);
                ry = mdr(absv(py), 64'd1 << FB, c2);
                e.range_dpx = clamp(px < 0, rx);
                e.range_dpy = clamp(py < 0, ry);
                e.bearing_dpx = clamp(!(py < 0), mdr(absv(py), 64'd1 << (2 * FB), c1));
                e.bearing_dpy = clamp(px < 0, mdr(absv(px), 64'd1 << (2 * FB), c1));
                sa = vx * py; sb = vy * px;
                if (sa >= sb) begin xm = sa - sb; xn = 0; end
                else begin xm = sb - sa; xn = 1; end
                e.rate_dpx = clamp((py < 0) != xn, mdr(ry, xm, c1));
                e.rate_dpy = clamp((px < 0) == xn, mdr(rx, xm, c1));
                e.degenerate = 1'b0;
            end
            pending.push_back(e);
        endfunction

        // Check one accepted Jacobian word
        function void check_word(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected word %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp r %h %h b %h %h rr %h %h d %b | got %h %h %h %h %h %h %b",
                        e.range_dpx, e.range_dpy, e.bearing_dpx, e.bearing_dpy,
                        e.rate_dpx, e.rate_dpy, e.degenerate,
                        got.range_dpx, got.range_dpy, got.bearing_dpx, got.bearing_dpy,
                        got.rate_dpx, got.rate_dpy, got.degenerate);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data;

    jacobian_sb sb;
    int         idle_cycles;

    radar_measurement_jacobian i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial sb = new();

    // Sink: stall pattern, check words, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && i_out_ready) sb.check_word(o_out_data);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            case ($urandom_range(0, 3))
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 9) != 0);
                2: i_out_ready <= ($urandom_range(0, 1) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_MAX) begin
            $display("radar_measurement_jacobian_tb: errors");
            $finish;
        end
    end

    // Hold a state word on the input until it is accepted; the caller drops
    // valid before the next edge unless another word follows at once
    task automatic send_state(t_in w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_state(w);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_thresh(logic [30:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.thresh = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_field(int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 << FB)) - (1 << FB));
            2: return 32'($signed($urandom_range(0, 400 << FB)) - (200 << FB));
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                           : 32'h8000_0000 + $urandom_range(0, 255);
            default: return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic t_in rand_state();
        t_in w;
        int  k;
        k = $urandom_range(0, 9);
        k = (k < 4) ? 2 : (k < 6) ? 1 : (k < 8) ? 0 : (k < 9) ? 3 : 4;
        w.pos_x = rand_field(k);
        w.pos_y = rand_field($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : k);
        w.vel_x = rand_field($urandom_range(0, 3));
        w.vel_y = rand_field($urandom_range(0, 3));
        return w;
    endfunction

    // Send a run of random words in bursts with gaps
    task automatic send_random(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0) begin
                send_state(rand_state());
                burst--; n--;
            end
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_directed();
        t_in w;
        logic [31:0] ext[6];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
        for (int j = 0; j < 6; j++) begin
            w = '{ext[j], ext[(j + 2) % 6], ext[(j + 1) % 6], ext[(j + 4) % 6]};
            send_state(w);
        end
        // zero vector, tiny ranges, unit vectors, extreme fields
        send_state('{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000});
        send_state('{32'h0000_2000, 32'h0000_0000, 32'h1, 32'h1});
        send_state('{32'h0000_0800, 32'h0000_0800, 32'h1, 32'h1});
        send_state('{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000});
        send_state('{32'h0, 32'hFFFF_0000, 32'h0003_0000, 32'h0});
        send_state('{32'h0000_0100, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000});
        send_state('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_state('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
        send_state('{32'h0000_0010, 32'hFFFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF});
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset threshold, then walk through other settings
        send_directed();
        send_random(400);
        wait_drain();
        write_thresh(31'd0);
        send_directed();
        send_random(300);
        wait_drain();
        write_thresh(31'h7FFF_FFFF);
        send_random(150);
        wait_drain();
        write_thresh(31'd1 << FB);
        send_random(400);
        wait_drain();
        write_thresh(31'd1);
        send_random(400);
        wait_drain();

        if (sb.n_err == 0) $display("radar_measurement_jacobian_tb: clean");
        else $display("radar_measurement_jacobian_tb: errors");
        $finish;
    end

endmodule

### radar_measurement_jacobian.f
design/rmj_pkg.sv
design/rmj_delay.sv
design/rmj_isqrt.sv
design/rmj_div.sv
design/radar_measurement_jacobian.sv
design/rmj_check.sv
sim/radar_measurement_jacobian_tb.sv
